>>> hw/rtl/pnc_pkg.sv
// pnc_pkg: shared constants, types and the fixed colour table of the nearest colour mapper
`default_nettype none
package pnc_pkg;

   localparam int FIRST_COLOR = 4;
   localparam int TABLE_ROWS  = 140;
   localparam int PAD_LANES   = 256;
   localparam int DIST_W      = 18;
   localparam int SQ_W        = 16;
   localparam int CSR_IDX_W   = 2;

   localparam logic [7:0] ALPHA_LIMIT = 8'd128;
   localparam logic [7:0] CLEAR_INDEX = 8'd0;

   typedef logic [DIST_W-1:0] dist_type;
   typedef logic [7:0]        pidx_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_USE_ALPHA = 2'd0,
      REG_USE_KEY   = 2'd1,
      REG_KEY_VALUE = 2'd2,
      REG_NONE      = 2'd3
   } csr_reg_type;

   localparam logic [23:0] COLORS [0:TABLE_ROWS-1] = '{
      {8'd89,8'd125,8'd39},{8'd109,8'd153,8'd48},{8'd127,8'd178,8'd56},{8'd67,8'd94,8'd29},
      {8'd174,8'd164,8'd115},{8'd213,8'd201,8'd140},{8'd247,8'd233,8'd163},
      {8'd130,8'd123,8'd86},
      {8'd117,8'd117,8'd117},{8'd144,8'd144,8'd144},{8'd167,8'd167,8'd167},
      {8'd88,8'd88,8'd88},
      {8'd180,8'd0,8'd0},{8'd220,8'd0,8'd0},{8'd255,8'd0,8'd0},{8'd135,8'd0,8'd0},
      {8'd112,8'd112,8'd180},{8'd138,8'd138,8'd220},{8'd160,8'd160,8'd255},
      {8'd84,8'd84,8'd135},
      {8'd117,8'd117,8'd117},{8'd144,8'd144,8'd144},{8'd167,8'd167,8'd167},
      {8'd88,8'd88,8'd88},
      {8'd0,8'd87,8'd0},{8'd0,8'd106,8'd0},{8'd0,8'd124,8'd0},{8'd0,8'd65,8'd0},
      {8'd180,8'd180,8'd180},{8'd220,8'd220,8'd220},{8'd255,8'd255,8'd255},
      {8'd135,8'd135,8'd135},
      {8'd115,8'd118,8'd129},{8'd141,8'd144,8'd158},{8'd164,8'd168,8'd184},
      {8'd86,8'd88,8'd97},
      {8'd129,8'd74,8'd33},{8'd157,8'd91,8'd40},{8'd183,8'd106,8'd47},{8'd96,8'd56,8'd24},
      {8'd79,8'd79,8'd79},{8'd96,8'd96,8'd96},{8'd112,8'd112,8'd112},{8'd59,8'd59,8'd59},
      {8'd45,8'd45,8'd180},{8'd55,8'd55,8'd220},{8'd64,8'd64,8'd255},{8'd33,8'd33,8'd135},
      {8'd73,8'd58,8'd35},{8'd89,8'd71,8'd43},{8'd104,8'd83,8'd50},{8'd55,8'd43,8'd26},
      {8'd180,8'd177,8'd172},{8'd220,8'd217,8'd211},{8'd255,8'd252,8'd245},
      {8'd135,8'd133,8'd129},
      {8'd152,8'd89,8'd36},{8'd186,8'd109,8'd44},{8'd216,8'd127,8'd51},
      {8'd114,8'd67,8'd27},
      {8'd125,8'd53,8'd152},{8'd153,8'd65,8'd186},{8'd178,8'd76,8'd216},
      {8'd94,8'd40,8'd114},
      {8'd72,8'd108,8'd152},{8'd88,8'd132,8'd186},{8'd102,8'd153,8'd216},
      {8'd54,8'd81,8'd114},
      {8'd161,8'd161,8'd36},{8'd197,8'd197,8'd44},{8'd229,8'd229,8'd51},
      {8'd121,8'd121,8'd27},
      {8'd89,8'd144,8'd17},{8'd109,8'd176,8'd21},{8'd127,8'd204,8'd25},
      {8'd67,8'd108,8'd13},
      {8'd170,8'd89,8'd116},{8'd208,8'd109,8'd142},{8'd242,8'd127,8'd165},
      {8'd128,8'd67,8'd87},
      {8'd53,8'd53,8'd53},{8'd65,8'd65,8'd65},{8'd76,8'd76,8'd76},{8'd40,8'd40,8'd40},
      {8'd108,8'd108,8'd108},{8'd132,8'd132,8'd132},{8'd153,8'd153,8'd153},
      {8'd81,8'd81,8'd81},
      {8'd53,8'd89,8'd108},{8'd65,8'd109,8'd132},{8'd76,8'd127,8'd153},
      {8'd40,8'd67,8'd81},
      {8'd89,8'd44,8'd125},{8'd109,8'd54,8'd153},{8'd127,8'd63,8'd178},
      {8'd67,8'd33,8'd94},
      {8'd36,8'd53,8'd125},{8'd44,8'd65,8'd153},{8'd51,8'd76,8'd178},{8'd27,8'd40,8'd94},
      {8'd72,8'd53,8'd36},{8'd88,8'd65,8'd44},{8'd102,8'd76,8'd51},{8'd54,8'd40,8'd27},
      {8'd72,8'd89,8'd36},{8'd88,8'd109,8'd44},{8'd102,8'd127,8'd51},{8'd54,8'd67,8'd27},
      {8'd108,8'd36,8'd36},{8'd132,8'd44,8'd44},{8'd153,8'd51,8'd51},{8'd81,8'd27,8'd27},
      {8'd17,8'd17,8'd17},{8'd21,8'd21,8'd21},{8'd25,8'd25,8'd25},{8'd13,8'd13,8'd13},
      {8'd176,8'd168,8'd54},{8'd215,8'd205,8'd66},{8'd250,8'd238,8'd77},
      {8'd132,8'd126,8'd40},
      {8'd64,8'd154,8'd150},{8'd79,8'd188,8'd183},{8'd92,8'd219,8'd213},
      {8'd48,8'd115,8'd112},
      {8'd52,8'd90,8'd180},{8'd63,8'd110,8'd220},{8'd74,8'd128,8'd255},
      {8'd39,8'd67,8'd135},
      {8'd0,8'd153,8'd40},{8'd0,8'd187,8'd50},{8'd0,8'd217,8'd58},{8'd0,8'd114,8'd30},
      {8'd14,8'd14,8'd21},{8'd18,8'd17,8'd26},{8'd21,8'd20,8'd31},{8'd11,8'd10,8'd16},
      {8'd79,8'd1,8'd0},{8'd96,8'd1,8'd0},{8'd112,8'd2,8'd0},{8'd59,8'd1,8'd0}
   };

endpackage
`default_nettype wire

>>> hw/rtl/pnc_if.sv
// pnc_if: pixel, index and register-write channel interfaces
`default_nettype none
interface pnc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic [7:0] raw_first_byte;
   modport source (output valid, red, green, blue, alpha, raw_first_byte, input ready);
   modport sink   (input valid, red, green, blue, alpha, raw_first_byte, output ready);
endinterface

interface pnc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] map_index;
   modport source (output valid, map_index, input ready);
   modport sink   (input valid, map_index, output ready);
endinterface

interface pnc_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/palette_nearest_color_mapper.sv
// palette_nearest_color_mapper: top level, pixel to nearest palette index pipeline
//
//  channel  dir  payload                                 handshake
//  req_ch   in   red green blue alpha raw_first_byte     valid/ready
//  rsp_ch   out  map_index                               valid/ready
//  csr_ch   in   index(2) data(8)                        valid/ready, always ready
//
// one word per cycle sustained while rsp_ch is ready; a word passes
// through squares, sum and four 4-to-1 minimum levels, each a stage
// each stage holds its word only while the stage after it is full and stalled
// reset clears valid bits and the configuration registers; datapath registers are not reset
`default_nettype none
module palette_nearest_color_mapper #(
   parameter int PALETTE_SIZE = 144
) (
   input  wire logic clock,
   input  wire logic reset,
   pnc_req_if.sink   req_ch,
   pnc_rsp_if.source rsp_ch,
   pnc_csr_if.sink   csr_ch
);
   localparam int LIMIT = (PALETTE_SIZE < pnc_pkg::FIRST_COLOR + pnc_pkg::TABLE_ROWS)
                        ? PALETTE_SIZE : pnc_pkg::FIRST_COLOR + pnc_pkg::TABLE_ROWS;
   localparam int LANES  = LIMIT - pnc_pkg::FIRST_COLOR;
   localparam int STAGES = 6;

   logic       use_alpha_ff, use_key_ff;
   logic [7:0] key_value_ff;

   logic [STAGES-1:0] v_ff, v_in, en;
   logic [STAGES-1:0] clr_ff;
   logic              clr_in;

   pnc_pkg::dist_type dist0 [0:pnc_pkg::PAD_LANES-1];
   pnc_pkg::pidx_type idx0  [0:pnc_pkg::PAD_LANES-1];
   pnc_pkg::dist_type dist1 [0:63];
   pnc_pkg::pidx_type idx1  [0:63];
   pnc_pkg::dist_type dist2 [0:15];
   pnc_pkg::pidx_type idx2  [0:15];
   pnc_pkg::dist_type dist3 [0:3];
   pnc_pkg::pidx_type idx3  [0:3];
   pnc_pkg::dist_type dist4 [0:0];
   pnc_pkg::pidx_type idx4  [0:0];

   // register writes
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         use_alpha_ff <= 1'b0;
         use_key_ff   <= 1'b0;
         key_value_ff <= '0;
      end else if (csr_ch.valid) begin
         case (pnc_pkg::csr_reg_type'(csr_ch.index))
            pnc_pkg::REG_USE_ALPHA: use_alpha_ff <= csr_ch.data[0];
            pnc_pkg::REG_USE_KEY:   use_key_ff   <= csr_ch.data[0];
            pnc_pkg::REG_KEY_VALUE: key_value_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // per-stage stall chain
   always_comb begin
      en[STAGES-1] = !v_ff[STAGES-1] || rsp_ch.ready;
      for (int k = STAGES-2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[0] = req_ch.valid;
      for (int k = 1; k < STAGES; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   assign req_ch.ready = en[0];
   assign clr_in = (use_alpha_ff && (req_ch.alpha < pnc_pkg::ALPHA_LIMIT))
                || (use_key_ff && (req_ch.raw_first_byte == key_value_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (en[k]) v_ff[k] <= v_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) clr_ff[0] <= clr_in;
      for (int k = 1; k < STAGES; k++) begin
         if (en[k]) clr_ff[k] <= clr_ff[k-1];
      end
   end

   genvar l;
   generate
      for (l = 0; l < pnc_pkg::PAD_LANES; l++) begin : g_idx
         assign idx0[l] = pnc_pkg::pidx_type'(l + pnc_pkg::FIRST_COLOR);
      end
   endgenerate

   pnc_dist #(.LANES(LANES)) u_dist (
      .clock (clock), .en_sq (en[0]), .en_sum (en[1]),
      .red (req_ch.red), .green (req_ch.green), .blue (req_ch.blue),
      .lane_dist (dist0)
   );

   pnc_min4 #(.IN_CNT(256)) u_min_a (
      .clock (clock), .en (en[2]), .dist_i (dist0), .idx_i (idx0),
      .dist_o (dist1), .idx_o (idx1));
   pnc_min4 #(.IN_CNT(64)) u_min_b (
      .clock (clock), .en (en[3]), .dist_i (dist1), .idx_i (idx1),
      .dist_o (dist2), .idx_o (idx2));
   pnc_min4 #(.IN_CNT(16)) u_min_c (
      .clock (clock), .en (en[4]), .dist_i (dist2), .idx_i (idx2),
      .dist_o (dist3), .idx_o (idx3));
   pnc_min4 #(.IN_CNT(4)) u_min_d (
      .clock (clock), .en (en[5]), .dist_i (dist3), .idx_i (idx3),
      .dist_o (dist4), .idx_o (idx4));

   assign rsp_ch.valid     = v_ff[STAGES-1];
   assign rsp_ch.map_index = clr_ff[STAGES-1] ? pnc_pkg::CLEAR_INDEX : idx4[0];

   // a non-transparent result always lies in the searched range
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.map_index != pnc_pkg::CLEAR_INDEX) |->
      (rsp_ch.map_index >= 8'(pnc_pkg::FIRST_COLOR) && rsp_ch.map_index < 8'(LIMIT)))
      else $error("map index out of searched range");

   // input back-pressure only when every stage holds a word
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (&v_ff))
      else $error("input stalled with a bubble in the pipeline");

   // a word leaving the last stage frees room at the input
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready) |-> req_ch.ready)
      else $error("input not ready while output drains");
endmodule
`default_nettype wire

>>> hw/rtl/pnc_dist.sv
// pnc_dist: two-stage squared distance from the pixel to every palette lane
`default_nettype none
module pnc_dist #(
   parameter int LANES = 140
) (
   input  wire logic                 clock,
   input  wire logic                 en_sq,
   input  wire logic                 en_sum,
   input  wire logic [7:0]           red,
   input  wire logic [7:0]           green,
   input  wire logic [7:0]           blue,
   output pnc_pkg::dist_type         lane_dist [0:pnc_pkg::PAD_LANES-1]
);
   genvar l;
   generate
      for (l = 0; l < pnc_pkg::PAD_LANES; l++) begin : g_lane
         if (l < LANES) begin : g_real
            logic [7:0]             cr, cg, cb, dr, dg, db;
            logic [pnc_pkg::SQ_W-1:0] sr_ff, sg_ff, sb_ff;
            pnc_pkg::dist_type      dist_ff;
            assign cr = pnc_pkg::COLORS[l][23:16];
            assign cg = pnc_pkg::COLORS[l][15:8];
            assign cb = pnc_pkg::COLORS[l][7:0];
            assign dr = (red   > cr) ? red   - cr : cr - red;
            assign dg = (green > cg) ? green - cg : cg - green;
            assign db = (blue  > cb) ? blue  - cb : cb - blue;
            always_ff @(posedge clock) begin
               if (en_sq) begin
                  sr_ff <= dr * dr;
                  sg_ff <= dg * dg;
                  sb_ff <= db * db;
               end
               if (en_sum) begin
                  dist_ff <= pnc_pkg::DIST_W'(sr_ff) + pnc_pkg::DIST_W'(sg_ff)
                           + pnc_pkg::DIST_W'(sb_ff);
               end
            end
            assign lane_dist[l] = dist_ff;
         end else begin : g_pad
            // unused lane, loses every compare
            assign lane_dist[l] = '1;
         end
      end
   endgenerate
endmodule
`default_nettype wire

>>> hw/rtl/pnc_min4.sv
// pnc_min4: one registered 4-to-1 level of the minimum-distance tree
`default_nettype none
module pnc_min4 #(
   parameter int IN_CNT = 256
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  pnc_pkg::dist_type         dist_i [0:IN_CNT-1],
   input  pnc_pkg::pidx_type         idx_i  [0:IN_CNT-1],
   output pnc_pkg::dist_type         dist_o [0:IN_CNT/4-1],
   output pnc_pkg::pidx_type         idx_o  [0:IN_CNT/4-1]
);
   genvar g;
   generate
      for (g = 0; g < IN_CNT/4; g++) begin : g_grp
         pnc_pkg::dist_type d01, d23;
         pnc_pkg::pidx_type i01, i23;
         pnc_pkg::dist_type dist_ff;
         pnc_pkg::pidx_type idx_ff;
         // strict less-than keeps the lower index on ties
         assign d01 = (dist_i[4*g+1] < dist_i[4*g])   ? dist_i[4*g+1] : dist_i[4*g];
         assign i01 = (dist_i[4*g+1] < dist_i[4*g])   ? idx_i[4*g+1]  : idx_i[4*g];
         assign d23 = (dist_i[4*g+3] < dist_i[4*g+2]) ? dist_i[4*g+3] : dist_i[4*g+2];
         assign i23 = (dist_i[4*g+3] < dist_i[4*g+2]) ? idx_i[4*g+3]  : idx_i[4*g+2];
         always_ff @(posedge clock) begin
            if (en) begin
               dist_ff <= (d23 < d01) ? d23 : d01;
               idx_ff  <= (d23 < d01) ? i23 : i01;
            end
         end
         assign dist_o[g] = dist_ff;
         assign idx_o[g]  = idx_ff;
      end
   endgenerate
endmodule
`default_nettype wire
